>>> hw/rtl/sms_pkg.sv
// Package for the dual-stream splitmix64 generator.
// Holds command codes, sequencer states and the mixing constants.
// No dependencies.
package sms_pkg;

  typedef enum logic [1:0] {
    CMD_DRAW        = 2'd0,
    CMD_BATTLE_SEED = 2'd1,
    CMD_SET_MODE    = 2'd2,
    CMD_FREE_SEED   = 2'd3
  } sms_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } sms_state_t;

  localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;
  localparam logic [63:0] BATTLE_INIT = 64'hDEADBEEFCAFEF00D;
  localparam logic [63:0] FREE_MASK   = 64'hA5A5A5A55A5A5A5A;
  localparam logic [63:0] FREE_INIT   = 64'h0123456789ABCDEF;
  localparam logic [31:0] TALLY_MAX   = 32'hFFFFFFFF;
  // four discarded warm-up advances leave the state at seed + 4 * step
  localparam logic [63:0] WARMUP_STEP = GOLDEN_STEP * 64'd4;

  // partial-product index within one 64 x 64 (low half) multiply
  localparam logic [1:0] PART_LO_LO = 2'd0;
  localparam logic [1:0] PART_HI_LO = 2'd1;
  localparam logic [1:0] PART_LO_HI = 2'd2;

endpackage

>>> hw/rtl/sms_if.sv
// Channel interfaces for the dual-stream splitmix64 generator.
// sms_cmd_if carries commands in, sms_res_if carries results out.
// Depends on sms_pkg.
interface sms_cmd_if;
  import sms_pkg::*;
  logic        valid;
  logic        ready;
  sms_cmd_t    command;
  logic [63:0] seed_value;
  logic        mode_on;

  modport source (output valid, command, seed_value, mode_on, input ready);
  modport sink (input valid, command, seed_value, mode_on, output ready);
endinterface

interface sms_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;
  logic        from_battle;
  logic [31:0] battle_count;
  logic [31:0] free_count;

  modport source (output valid, random_word, from_battle, battle_count, free_count,
                  input ready);
  modport sink (input valid, random_word, from_battle, battle_count, free_count,
                output ready);
endinterface

>>> hw/rtl/dual_stream_splitmix_generator.sv
// Dual-stream splitmix64 generator, top level.
// Depends on sms_pkg and the channel interfaces in sms_if.sv.
//
// Usage:
//   cmd  : one command per transfer (draw, load battle seed, set battle mode,
//          load free seed). Every command yields exactly one result on res.
//   res  : random word (zero unless a draw), stream flag, and both saturating
//          draw counts as they stand after the command.
// Timing:
//   A non-draw command is answered in the cycle after its transfer.
//   A draw runs two 64-bit mixing multiplies, each as three 32 x 32 partial
//   products through one shared multiplier, a multiply state (ST_MUL) and an
//   accumulate state (ST_ACC) per partial, then ST_FIN loads the output register;
//   cmd.ready stays low meanwhile, so no new command is taken until the draw ends.
//   The shared multiplier sequence sets the draw rate.
// Reset (rst, synchronous): both stream states take their fixed seeds, battle
//   mode off, counts zero, no result pending.
// Stall: a result waits in the output register until res.ready; a command is
//   taken while idle and the output is empty or being taken in the same cycle.
module dual_stream_splitmix_generator (
  input logic      clk,
  input logic      rst,
  sms_cmd_if.sink  cmd,
  sms_res_if.source res
);
  import sms_pkg::*;

  sms_state_t  state, state_next;
  logic [63:0] battle_stream, free_stream;
  logic        battle_selected;
  logic [31:0] battle_tally, free_tally;
  logic        sel_battle;
  logic [63:0] x, acc, prod, acc_sum, z_out;
  logic [1:0]  part;
  logic        rnd;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_k, s_base, s_new;
  logic        out_valid;
  logic        out_free, cmd_xfer, fin_go;

  assign out_free  = !out_valid || res.ready;
  assign cmd.ready = (state == ST_IDLE) && out_free;
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign fin_go    = (state == ST_FIN) && out_free;

  assign mul_k   = rnd ? MIX_MUL_B : MIX_MUL_A;
  assign mul_a   = (part == PART_HI_LO) ? x[63:32] : x[31:0];
  assign mul_b   = (part == PART_LO_HI) ? mul_k[63:32] : mul_k[31:0];
  assign acc_sum = (part == PART_LO_LO) ? prod : acc + {prod[31:0], 32'd0};
  assign z_out   = acc ^ (acc >> 31);

  assign s_base = battle_selected ? battle_stream : free_stream;
  assign s_new  = s_base + GOLDEN_STEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_xfer && cmd.command == CMD_DRAW) state_next = ST_MUL;
      end
      ST_MUL: state_next = ST_ACC;
      ST_ACC: begin
        if (part == PART_LO_HI && rnd) state_next = ST_FIN;
        else state_next = ST_MUL;
      end
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // stream state, mode and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      battle_stream   <= BATTLE_INIT;
      free_stream     <= FREE_INIT;
      battle_selected <= 1'b0;
      battle_tally    <= '0;
      free_tally      <= '0;
    end else begin
      if (cmd_xfer) begin
        case (cmd.command)
          CMD_DRAW: begin
            if (battle_selected) battle_stream <= s_new;
            else free_stream <= s_new;
          end
          CMD_BATTLE_SEED: battle_stream <= cmd.seed_value + WARMUP_STEP;
          CMD_SET_MODE:    battle_selected <= cmd.mode_on;
          CMD_FREE_SEED:   free_stream <= cmd.seed_value ^ FREE_MASK;
          default: ;
        endcase
      end
      if (fin_go) begin
        if (sel_battle) begin
          if (battle_tally != TALLY_MAX) battle_tally <= battle_tally + 32'd1;
        end else begin
          if (free_tally != TALLY_MAX) free_tally <= free_tally + 32'd1;
        end
      end
    end
  end

  // mixing datapath: one shared 32 x 32 multiplier, registered product
  always_ff @(posedge clk) begin
    if (cmd_xfer && cmd.command == CMD_DRAW) begin
      x          <= s_new ^ (s_new >> 30);
      sel_battle <= battle_selected;
      part       <= PART_LO_LO;
      rnd        <= 1'b0;
    end
    if (state == ST_MUL) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    if (state == ST_ACC) begin
      acc <= acc_sum;
      if (part == PART_LO_HI) begin
        part <= PART_LO_LO;
        if (!rnd) begin
          x   <= acc_sum ^ (acc_sum >> 27);
          rnd <= 1'b1;
        end
      end else begin
        part <= part + 2'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go || cmd_xfer && cmd.command != CMD_DRAW) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      res.random_word  <= z_out[31:0];
      res.from_battle  <= sel_battle;
      res.battle_count <= (sel_battle && battle_tally != TALLY_MAX) ?
                          battle_tally + 32'd1 : battle_tally;
      res.free_count   <= (!sel_battle && free_tally != TALLY_MAX) ?
                          free_tally + 32'd1 : free_tally;
    end else if (cmd_xfer && cmd.command != CMD_DRAW) begin
      res.random_word  <= '0;
      res.from_battle  <= 1'b0;
      res.battle_count <= battle_tally;
      res.free_count   <= free_tally;
    end
  end

  assign res.valid = out_valid;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !cmd.ready)
    else $error("command taken while sequencer busy");

  a_cmd_answer: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer && cmd.command != CMD_DRAW |=> out_valid && res.random_word == 32'd0)
    else $error("non-draw command not answered next cycle");

  a_battle_tally: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && battle_tally != $past(battle_tally) |->
      $past(state == ST_FIN) && $past(sel_battle))
    else $error("battle count changed outside a battle draw");

  a_free_tally: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && free_tally != $past(free_tally) |->
      $past(state == ST_FIN) && !$past(sel_battle))
    else $error("free count changed outside a free draw");

endmodule

>>> test/sms_draw_checker.sv
// Checker for the dual-stream splitmix64 generator: watches both channels,
// predicts each result from its own copy of the stream state and compares.
// Depends on sms_pkg and the channel interfaces in sms_if.sv.
`timescale 1ns / 1ps

module sms_draw_checker (
  input  logic clk,
  input  logic rst,
  sms_cmd_if   cmd_mon,
  sms_res_if   res_mon,
  output int   mismatches,
  output int   outstanding
);
  import sms_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic        from_battle;
    logic [31:0] battle_count;
    logic [31:0] free_count;
  } draw_result_t;

  logic [63:0]  pred_battle;
  logic [63:0]  pred_free;
  logic         pred_sel;
  logic [31:0]  pred_battle_cnt;
  logic [31:0]  pred_free_cnt;
  draw_result_t pending_results[$];

  function automatic logic [63:0] splitmix_scramble(input logic [63:0] z);
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic predict_command(input sms_cmd_t c, input logic [63:0] seed,
                                 input logic mode);
    draw_result_t r;
    logic [63:0]  mixed;
    r = '0;
    case (c)
      CMD_DRAW: begin
        if (pred_sel) begin
          pred_battle = pred_battle + GOLDEN_STEP;
          mixed = splitmix_scramble(pred_battle);
          r.word = mixed[31:0];
          r.from_battle = 1'b1;
          if (pred_battle_cnt != TALLY_MAX) pred_battle_cnt++;
        end else begin
          pred_free = pred_free + GOLDEN_STEP;
          mixed = splitmix_scramble(pred_free);
          r.word = mixed[31:0];
          if (pred_free_cnt != TALLY_MAX) pred_free_cnt++;
        end
      end
      CMD_BATTLE_SEED: begin
        // warm-up outputs are thrown away, only the state moves
        pred_battle = seed;
        for (int i = 0; i < 4; i++) pred_battle = pred_battle + GOLDEN_STEP;
      end
      CMD_SET_MODE: pred_sel = mode;
      CMD_FREE_SEED: pred_free = seed ^ FREE_MASK;
      default: ;
    endcase
    r.battle_count = pred_battle_cnt;
    r.free_count = pred_free_cnt;
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    draw_result_t want;
    if (rst) begin
      pred_battle = BATTLE_INIT;
      pred_free = FREE_INIT;
      pred_sel = 1'b0;
      pred_battle_cnt = '0;
      pred_free_cnt = '0;
      pending_results.delete();
    end else begin
      if (cmd_mon.valid && cmd_mon.ready)
        predict_command(cmd_mon.command, cmd_mon.seed_value, cmd_mon.mode_on);
      if (res_mon.valid && res_mon.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transfer", {32'd0, res_mon.random_word}, '0);
        end else begin
          want = pending_results.pop_front();
          if (res_mon.random_word !== want.word)
            report_mismatch("random_word", 64'(res_mon.random_word), 64'(want.word));
          if (res_mon.from_battle !== want.from_battle)
            report_mismatch("from_battle", 64'(res_mon.from_battle),
                            64'(want.from_battle));
          if (res_mon.battle_count !== want.battle_count)
            report_mismatch("battle_count", 64'(res_mon.battle_count),
                            64'(want.battle_count));
          if (res_mon.free_count !== want.free_count)
            report_mismatch("free_count", 64'(res_mon.free_count),
                            64'(want.free_count));
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

>>> test/dual_stream_splitmix_generator_tb.sv
// Top of the dual-stream splitmix64 generator bench: clock, reset, command
// stimulus with random idling and back-pressure, and the final verdict.
// Depends on sms_pkg, sms_if.sv, the generator RTL and sms_draw_checker.
`timescale 1ns / 1ps

module dual_stream_splitmix_generator_tb;
  import sms_pkg::*;

  localparam int PHASE_ITEMS = 450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle = 37;
  int   recv_idle = 48;
  logic hold_req = 1'b0;
  logic hold_started = 1'b0;
  int   hold_off = 0;
  int   mismatches;
  int   outstanding;

  sms_cmd_if cmd_ch ();
  sms_res_if res_ch ();

  dual_stream_splitmix_generator dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  sms_draw_checker checker_i (
    .clk(clk),
    .rst(rst),
    .cmd_mon(cmd_ch),
    .res_mon(res_ch),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  always #4 clk = ~clk;

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_cmd(input sms_cmd_t c, input logic [63:0] seed, input logic mode);
    while ($urandom_range(99) < send_idle) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= c;
    cmd_ch.seed_value <= seed;
    cmd_ch.mode_on <= mode;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_off = 300;
      end
      if (hold_off > 0) begin
        hold_off--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    sms_cmd_t    c;
    logic [63:0] seed;
    int          pick;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_DRAW;
    cmd_ch.seed_value = '0;
    cmd_ch.mode_on = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset streams, ignored fields, seed extremes, mode switches
    send_cmd(CMD_DRAW, '0, 1'b0);
    send_cmd(CMD_DRAW, '1, 1'b1);
    send_cmd(CMD_SET_MODE, '1, 1'b1);
    send_cmd(CMD_DRAW, '0, 1'b0);
    send_cmd(CMD_DRAW, '1, 1'b0);
    send_cmd(CMD_BATTLE_SEED, '0, 1'b1);
    send_cmd(CMD_DRAW, '0, 1'b0);
    send_cmd(CMD_BATTLE_SEED, '1, 1'b0);
    send_cmd(CMD_DRAW, '0, 1'b0);
    send_cmd(CMD_FREE_SEED, FREE_MASK, 1'b1);
    send_cmd(CMD_DRAW, '0, 1'b0);
    send_cmd(CMD_SET_MODE, '0, 1'b0);
    send_cmd(CMD_DRAW, '0, 1'b1);
    send_cmd(CMD_FREE_SEED, '0, 1'b0);
    send_cmd(CMD_DRAW, '1, 1'b0);
    send_cmd(CMD_FREE_SEED, '1, 1'b1);
    send_cmd(CMD_DRAW, '0, 1'b0);
    send_cmd(CMD_BATTLE_SEED, 64'h8000_0000_0000_0001, 1'b1);
    send_cmd(CMD_SET_MODE, 64'h5555_5555_5555_5555, 1'b1);
    send_cmd(CMD_DRAW, '0, 1'b0);
    send_cmd(CMD_SET_MODE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_cmd(CMD_DRAW, '0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle = 48;
        recv_idle = 37;
      end else if (phase == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 100) hold_req = 1'b1;
        pick = $urandom_range(99);
        if (pick < 60) c = CMD_DRAW;
        else if (pick < 70) c = CMD_BATTLE_SEED;
        else if (pick < 80) c = CMD_FREE_SEED;
        else c = CMD_SET_MODE;
        pick = $urandom_range(19);
        if (pick == 0) seed = '0;
        else if (pick == 1) seed = '1;
        else seed = {$urandom, $urandom};
        send_cmd(c, seed, 1'($urandom_range(1)));
      end
    end

    cmd_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/sms_pkg.sv
hw/rtl/sms_if.sv
hw/rtl/dual_stream_splitmix_generator.sv
test/sms_draw_checker.sv
test/dual_stream_splitmix_generator_tb.sv
